// ===== rtl/bht_pkg.sv =====
// Shared types and constants for the bitmap handle table.
package bht_pkg;

    localparam int NUM_SLOTS_DEF    = 64;
    localparam int HANDLE_WIDTH_DEF = 32;

    localparam int ACTION_W      = 2;
    localparam int SLOT_IDX_W    = 6;
    localparam int HANDLE_PORT_W = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_UNUSED = 2'd2
    } status_t;

endpackage

// ===== rtl/bitmap_handle_table.sv =====
// Bitmap handle table: a fixed set of slots with an occupancy bitmap; an insert
// takes the lowest free slot and stores the handle there, a remove frees a slot
// and a lookup returns the stored handle of a slot in use. The block sustains
// one transaction per clock cycle while the result side does not stall; a
// request is loaded into the input stage, where the handle memory is read, and
// from there into the result register, and it waits in the input stage while
// the result side stalls. The rate rests on the combinational find-first-zero
// over the occupancy flip-flops and the one write port and one registered read
// port of the handle memory; a write to the slot being read in the same cycle
// is forwarded. Occupancy is cleared at reset; the handle memory is not cleared
// and needs no clearing pass, as a stored handle is returned only after an insert
// wrote it.
module bitmap_handle_table
    import bht_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [ACTION_W-1:0]      action,
    input  logic [SLOT_IDX_W-1:0]    slot_index,
    input  logic [HANDLE_PORT_W-1:0] handle_in,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [SLOT_IDX_W-1:0]    slot_out,
    output logic [HANDLE_PORT_W-1:0] handle_out,
    output logic [STATUS_W-1:0]      status
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [HANDLE_WIDTH-1:0]  mem [NUM_SLOTS];

    logic                     s1_valid_reg;
    logic [ACTION_W-1:0]      s1_action_reg;
    logic [SLOT_IDX_W-1:0]    s1_idx_reg;
    logic [HANDLE_PORT_W-1:0] s1_handle_reg;
    logic [HANDLE_WIDTH-1:0]  rd_data_reg;

    logic [NUM_SLOTS-1:0]     occ_reg;
    logic [NUM_SLOTS-1:0]     occ_next;

    logic                     rsp_valid_reg;
    logic [SLOT_IDX_W-1:0]    slot_reg;
    logic [SLOT_IDX_W-1:0]    slot_next;
    logic [HANDLE_PORT_W-1:0] handle_reg;
    logic [HANDLE_PORT_W-1:0] handle_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;

    logic                     s1_adv;
    logic                     s1_fire;
    logic                     req_acc;
    logic [SLOT_W-1:0]        rd_addr;
    logic [SLOT_W-1:0]        s1_addr;
    logic                     in_range;
    logic                     used;
    logic                     full;
    logic [NUM_SLOTS-1:0]     low_free;
    logic [SLOT_W-1:0]        free_slot;
    logic                     wr_en;
    logic                     wr_fire;
    logic [HANDLE_WIDTH-1:0]  wr_data;

    assign s1_adv    = !rsp_valid_reg || !rsp_stall;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign req_stall = s1_valid_reg && !s1_adv;
    assign req_acc   = req_valid && !req_stall;

    assign rd_addr   = SLOT_W'(slot_index);
    assign s1_addr   = SLOT_W'(s1_idx_reg);
    assign in_range  = int'(s1_idx_reg) < NUM_SLOTS;
    assign used      = in_range && occ_reg[s1_addr];
    assign full      = &occ_reg;
    // lowest clear bit of the bitmap as a one-hot word
    assign low_free  = ~occ_reg & (occ_reg + NUM_SLOTS'(1));
    assign wr_data   = HANDLE_WIDTH'(s1_handle_reg);
    assign wr_fire   = s1_fire && wr_en;

    always_comb
    begin
        free_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (low_free[i])
            begin
                free_slot = free_slot | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        occ_next    = occ_reg;
        wr_en       = 1'b0;
        slot_next   = s1_idx_reg;
        handle_next = '0;
        status_next = ST_UNUSED;
        case (s1_action_reg)
            ACT_INSERT:
            begin
                if (full)
                begin
                    slot_next   = '0;
                    status_next = ST_FULL;
                end
                else
                begin
                    occ_next    = occ_reg | low_free;
                    wr_en       = 1'b1;
                    slot_next   = SLOT_IDX_W'(free_slot);
                    status_next = ST_OK;
                end
            end
            ACT_REMOVE:
            begin
                if (used)
                begin
                    occ_next[s1_addr] = 1'b0;
                    status_next       = ST_OK;
                end
            end
            ACT_LOOKUP:
            begin
                if (used)
                begin
                    handle_next = HANDLE_PORT_W'(rd_data_reg);
                    status_next = ST_OK;
                end
            end
            default:
            begin
                status_next = ST_UNUSED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (req_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_action_reg <= action;
            s1_idx_reg    <= slot_index;
            s1_handle_reg <= handle_in;
        end
        if (s1_fire)
        begin
            slot_reg   <= slot_next;
            handle_reg <= handle_next;
            status_reg <= status_next;
        end
    end

    // handle memory: one write, one registered read, write forwarded to a same-slot read
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem[free_slot] <= wr_data;
        end
        if (req_acc)
        begin
            if (wr_fire && free_slot == rd_addr)
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign slot_out   = slot_reg;
    assign handle_out = handle_reg;
    assign status     = status_reg;

endmodule

// ===== rtl/bht_checker.sv =====
// Port level checks for the bitmap handle table, bound to the top level.
module bht_checker
    import bht_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic                     req_stall,
    input  logic [ACTION_W-1:0]      action,
    input  logic [SLOT_IDX_W-1:0]    slot_index,
    input  logic [HANDLE_PORT_W-1:0] handle_in,
    input  logic                     rsp_valid,
    input  logic                     rsp_stall,
    input  logic [SLOT_IDX_W-1:0]    slot_out,
    input  logic [HANDLE_PORT_W-1:0] handle_out,
    input  logic [STATUS_W-1:0]      status
);

    // a stalled request transaction holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(action)
            && $stable(slot_index) && $stable(handle_in))
        else $error("request changed while stalled");

    // a stalled result transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(slot_out)
            && $stable(handle_out) && $stable(status))
        else $error("result changed while stalled");

    // with the result register empty the request side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty result register");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> slot_out == '0 && handle_out == '0)
        else $error("full result carries slot or handle");

    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && handle_out != '0 |-> status == ST_OK)
        else $error("handle returned without ok status");

endmodule

bind bitmap_handle_table bht_checker u_bht_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the bitmap handle table: directed and random transactions.
module testbench;
    import bht_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ACTION_W-1:0]      act;
        logic [SLOT_IDX_W-1:0]    idx;
        logic [HANDLE_PORT_W-1:0] hdl;
    } table_req_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0]    slot;
        logic [HANDLE_PORT_W-1:0] hdl;
        logic [STATUS_W-1:0]      stat;
    } table_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [ACTION_W-1:0] action = '0;
    logic [SLOT_IDX_W-1:0] slot_index = '0;
    logic [HANDLE_PORT_W-1:0] handle_in = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [SLOT_IDX_W-1:0] slot_out;
    logic [HANDLE_PORT_W-1:0] handle_out;
    logic [STATUS_W-1:0] status;

    table_req_t pending_reqs[$];
    table_rsp_t expected_rsps[$];

    // occupancy as the block should hold it, and as planned while generating
    logic [SLOTS-1:0] occ_model;
    logic [HANDLE_PORT_W-1:0] handle_model [SLOTS];
    logic [SLOTS-1:0] plan_occ;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;

    bitmap_handle_table DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .action     (action),
        .slot_index (slot_index),
        .handle_in  (handle_in),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .slot_out   (slot_out),
        .handle_out (handle_out),
        .status     (status)
    );

    always #1 clk = ~clk;

    function automatic int lowest_free(input logic [SLOTS-1:0] bits);
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!bits[s])
                return s;
        end
        return SLOTS;
    endfunction

    // update table state for one transaction and queue its expected result
    task automatic predict_table_op(input table_req_t req);
        table_rsp_t rsp;
        int s;
        rsp.slot = req.idx;
        rsp.hdl  = '0;
        rsp.stat = ST_UNUSED;
        if (req.act == ACT_INSERT)
        begin
            s = lowest_free(occ_model);
            if (s >= SLOTS)
            begin
                rsp.slot = '0;
                rsp.stat = ST_FULL;
            end
            else
            begin
                occ_model[s] = 1'b1;
                handle_model[s] = req.hdl;
                rsp.slot = s[SLOT_IDX_W-1:0];
                rsp.stat = ST_OK;
            end
        end
        else if (req.act == ACT_REMOVE)
        begin
            if (occ_model[req.idx])
            begin
                occ_model[req.idx] = 1'b0;
                rsp.stat = ST_OK;
            end
        end
        else if (req.act == ACT_LOOKUP)
        begin
            if (occ_model[req.idx])
            begin
                rsp.hdl  = handle_model[req.idx];
                rsp.stat = ST_OK;
            end
        end
        expected_rsps.push_back(rsp);
    endtask

    task automatic push_req(input logic [ACTION_W-1:0] act, input int idx,
                            input logic [HANDLE_PORT_W-1:0] hdl);
        table_req_t req;
        int s;
        req.act = act;
        req.idx = idx[SLOT_IDX_W-1:0];
        req.hdl = hdl;
        if (act == ACT_INSERT)
        begin
            s = lowest_free(plan_occ);
            if (s < SLOTS)
                plan_occ[s] = 1'b1;
        end
        else if (act == ACT_REMOVE)
            plan_occ[req.idx] = 1'b0;
        pending_reqs.push_back(req);
    endtask

    function automatic int pick_used_slot();
        int start;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            if (plan_occ[(start + k) % SLOTS])
                return (start + k) % SLOTS;
        end
        return start;
    endfunction

    // random mix with the given insert and remove shares; queue_phase runs an insert-heavy then a remove-heavy block
    task automatic queue_random(input int count, input int insert_pct, input int remove_pct);
        int r;
        int idx;
        logic [ACTION_W-1:0] act;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                act = ACT_SPARE;
            else if (r < 3 + insert_pct)
                act = ACT_INSERT;
            else if (r < 3 + insert_pct + remove_pct)
                act = ACT_REMOVE;
            else
                act = ACT_LOOKUP;
            if ((act == ACT_REMOVE || act == ACT_LOOKUP) && $urandom_range(99) < 80)
                idx = pick_used_slot();
            else
                idx = $urandom_range(SLOTS - 1);
            push_req(act, idx, $urandom);
        end
    endtask

    task automatic queue_phase();
        queue_random(160, 70, 12);
        queue_random(160, 20, 50);
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            action     <= '0;
            slot_index <= '0;
            handle_in  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_table_op('{act: action, idx: slot_index, hdl: handle_in});
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    table_req_t req;
                    req = pending_reqs.pop_front();
                    req_valid  <= 1'b1;
                    action     <= req.act;
                    slot_index <= req.idx;
                    handle_in  <= req.hdl;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                    note_mismatch($sformatf("unexpected transaction slot %0d handle %h status %0d",
                                            slot_out, handle_out, status));
                else
                begin
                    table_rsp_t exp_rsp;
                    exp_rsp = expected_rsps.pop_front();
                    if (slot_out !== exp_rsp.slot || handle_out !== exp_rsp.hdl
                        || status !== exp_rsp.stat)
                        note_mismatch($sformatf(
                            "expected slot %0d handle %h status %0d, got slot %0d handle %h status %0d",
                            exp_rsp.slot, exp_rsp.hdl, exp_rsp.stat,
                            slot_out, handle_out, status));
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        occ_model = '0;
        plan_occ = '0;
        foreach (handle_model[i])
            handle_model[i] = '0;

        // empty table, spare code, fill a few, free and reuse the lowest slot
        push_req(ACT_LOOKUP, 0, 32'h0);
        push_req(ACT_REMOVE, SLOTS - 1, 32'hFFFF_FFFF);
        push_req(ACT_SPARE, SLOTS - 1, 32'hFFFF_FFFF);
        push_req(ACT_INSERT, SLOTS - 1, 32'h0);
        push_req(ACT_INSERT, 0, 32'hFFFF_FFFF);
        push_req(ACT_INSERT, 42, 32'hA5A5_A5A5);
        push_req(ACT_LOOKUP, 0, 32'h0);
        push_req(ACT_LOOKUP, 1, 32'h0);
        push_req(ACT_LOOKUP, 2, 32'hFFFF_FFFF);
        push_req(ACT_REMOVE, 1, 32'h0);
        push_req(ACT_LOOKUP, 1, 32'h0);
        push_req(ACT_REMOVE, 1, 32'h0);
        push_req(ACT_INSERT, 21, 32'h5A5A_5A5A);
        push_req(ACT_LOOKUP, 1, 32'h0);
        push_req(ACT_LOOKUP, SLOTS - 1, 32'h0);
        push_req(ACT_SPARE, 0, 32'h1234_5678);
        push_req(ACT_LOOKUP, 0, 32'h0);
        push_req(ACT_REMOVE, 0, 32'h0);
        push_req(ACT_REMOVE, 2, 32'h0);
        push_req(ACT_REMOVE, 1, 32'h0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            queue_phase();
            while (pending_reqs.size() != 0)
                @(negedge clk);
        end

        while (req_valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bht_pkg.sv
rtl/bitmap_handle_table.sv
rtl/bht_checker.sv
sim/testbench.sv
